@@ design/sfgr_pkg.sv @@
// shared types and constants of the segment font glyph raster unit
// stroke segment masks, glyph geometry limits and the queued item type
// no dependencies
`timescale 1ns / 1ps

package sfgr_pkg;

  // largest glyph side and field widths
  localparam int MAX_SIZE = 12;
  localparam int ROW_W    = 12;
  localparam int NUM_W    = 4;
  localparam int SEG_W    = 14;

  // smallest glyph side
  localparam logic [NUM_W-1:0] MIN_N = 4'd8;
  localparam logic [NUM_W-1:0] MAX_N = NUM_W'(MAX_SIZE);

  // configuration register indexes
  localparam logic [0:0] REG_FONT_SIZE = 1'b0;
  localparam logic [0:0] REG_BOLD      = 1'b1;

  // stroke segment masks
  localparam logic [SEG_W-1:0] SEG_TOP = 14'h0001;
  localparam logic [SEG_W-1:0] SEG_TL  = 14'h0002;
  localparam logic [SEG_W-1:0] SEG_TLD = 14'h0004;
  localparam logic [SEG_W-1:0] SEG_TM  = 14'h0008;
  localparam logic [SEG_W-1:0] SEG_TRD = 14'h0010;
  localparam logic [SEG_W-1:0] SEG_TR  = 14'h0020;
  localparam logic [SEG_W-1:0] SEG_LM  = 14'h0040;
  localparam logic [SEG_W-1:0] SEG_RM  = 14'h0080;
  localparam logic [SEG_W-1:0] SEG_BL  = 14'h0100;
  localparam logic [SEG_W-1:0] SEG_BLD = 14'h0200;
  localparam logic [SEG_W-1:0] SEG_BM  = 14'h0400;
  localparam logic [SEG_W-1:0] SEG_BRD = 14'h0800;
  localparam logic [SEG_W-1:0] SEG_BR  = 14'h1000;
  localparam logic [SEG_W-1:0] SEG_BOT = 14'h2000;

  // classified letter as held between front and back
  typedef struct packed {
    logic [SEG_W-1:0] segs;
    logic             unsupported;
  } sfgr_item_t;

endpackage

@@ design/segment_font_glyph_raster_unit.sv @@
// top level of the segment font glyph raster unit
// depends on sfgr_pkg, sfgr_front, sfgr_queue, sfgr_back
`timescale 1ns / 1ps

// usage
//   letter input: in_valid / in_ready carry one ASCII letter_code per item.
//   row output: out_valid / out_ready carry one glyph row per item, top row
//   first, with row_bits (bit c is column c), row_number and last_row; a code
//   outside A-Z and a-z gives a single item with unsupported and last_row set.
//   config: cfg_we writes cfg_data to register cfg_index (0 font_size,
//   1 bold) in the same edge; write only while the unit is idle.
// order and throughput
//   a taken letter goes into the queue, then its first row into the output
//   register. a letter gives font_size rows (clamped to 8..12), one for an
//   unsupported code; the single output register takes one row per cycle
//   while free or drained. queued letters follow each other with no gap;
//   the two-entry queue lets the input keep accepting while rows go out.
// reset and stall
//   reset empties the queue and the output, font_size becomes 8, bold 0.
//   when out_ready is low the current row holds, the queue fills and then
//   in_ready drops until rows drain again.
module segment_font_glyph_raster_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  letter_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] row_bits,
  output logic [3:0]  row_number,
  output logic        last_row,
  output logic        unsupported
);
  import sfgr_pkg::*;

  logic       font_bold;
  logic [3:0] font_size;
  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_head_valid;
  sfgr_item_t q_item;
  sfgr_item_t q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      font_size <= MIN_N;
      font_bold <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FONT_SIZE: font_size <= cfg_data;
        REG_BOLD:      font_bold <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  sfgr_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .letter_code (letter_code),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_item)
  );

  sfgr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head)
  );

  sfgr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .font_size   (font_size),
    .bold        (font_bold),
    .head_valid  (q_head_valid),
    .head_item   (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .row_bits    (row_bits),
    .row_number  (row_number),
    .last_row    (last_row),
    .unsupported (unsupported)
  );

endmodule

@@ design/sfgr_front.sv @@
// front end: accepts letter codes and classifies them into stroke sets
// depends on sfgr_pkg
`timescale 1ns / 1ps

module sfgr_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         letter_code,
  input  logic               q_full,
  output logic               q_push,
  output sfgr_pkg::sfgr_item_t q_item
);
  import sfgr_pkg::*;

  logic       is_upper;
  logic       is_lower;
  logic [4:0] slot;

  // stroke set of each letter, slot 0 is A
  function automatic logic [SEG_W-1:0] glyph_segs(input logic [4:0] s);
    logic [SEG_W-1:0] m;
    case (s)
      5'd0:  m = SEG_TOP | SEG_TL | SEG_TR | SEG_LM | SEG_RM | SEG_BL | SEG_BR;
      5'd1:  m = SEG_TOP | SEG_TM | SEG_TR | SEG_RM | SEG_BM | SEG_BR | SEG_BOT;
      5'd2:  m = SEG_TOP | SEG_TL | SEG_BL | SEG_BOT;
      5'd3:  m = SEG_TOP | SEG_TM | SEG_TR | SEG_BM | SEG_BR | SEG_BOT;
      5'd4:  m = SEG_TOP | SEG_TL | SEG_LM | SEG_BL | SEG_BOT;
      5'd5:  m = SEG_TOP | SEG_TL | SEG_LM | SEG_BL;
      5'd6:  m = SEG_TOP | SEG_TL | SEG_RM | SEG_BL | SEG_BR | SEG_BOT;
      5'd7:  m = SEG_TL | SEG_TR | SEG_RM | SEG_LM | SEG_BL | SEG_BR;
      5'd8:  m = SEG_TOP | SEG_TM | SEG_BM | SEG_BOT;
      5'd9:  m = SEG_TR | SEG_BL | SEG_BR | SEG_BOT;
      5'd10: m = SEG_TL | SEG_TRD | SEG_LM | SEG_BL | SEG_BRD;
      5'd11: m = SEG_TL | SEG_BL | SEG_BOT;
      5'd12: m = SEG_TL | SEG_TLD | SEG_TRD | SEG_TR | SEG_BL | SEG_BR;
      5'd13: m = SEG_TL | SEG_TLD | SEG_TR | SEG_BL | SEG_BRD | SEG_BR;
      5'd14: m = SEG_TOP | SEG_TL | SEG_TR | SEG_BL | SEG_BR | SEG_BOT;
      5'd15: m = SEG_TOP | SEG_TL | SEG_TR | SEG_LM | SEG_RM | SEG_BL;
      5'd16: m = SEG_TOP | SEG_TL | SEG_TR | SEG_BL | SEG_BRD | SEG_BR | SEG_BOT;
      5'd17: m = SEG_TOP | SEG_TL | SEG_TR | SEG_LM | SEG_RM | SEG_BL | SEG_BRD;
      5'd18: m = SEG_TOP | SEG_TL | SEG_LM | SEG_RM | SEG_BR | SEG_BOT;
      5'd19: m = SEG_TOP | SEG_TM | SEG_BM;
      5'd20: m = SEG_TL | SEG_TR | SEG_BL | SEG_BR | SEG_BOT;
      5'd21: m = SEG_TL | SEG_TRD | SEG_BL | SEG_BLD;
      5'd22: m = SEG_TL | SEG_TR | SEG_BL | SEG_BLD | SEG_BRD | SEG_BR;
      5'd23: m = SEG_TLD | SEG_TRD | SEG_BLD | SEG_BRD;
      5'd24: m = SEG_TLD | SEG_TRD | SEG_BM;
      5'd25: m = SEG_TOP | SEG_TRD | SEG_BLD | SEG_BOT;
      default: m = '0;
    endcase
    return m;
  endfunction

  // letter range checks, either case maps to the same slot
  assign is_upper = (letter_code >= 8'h41) && (letter_code <= 8'h5A);
  assign is_lower = (letter_code >= 8'h61) && (letter_code <= 8'h7A);

  always_comb begin
    if (is_lower) begin
      slot = 5'(letter_code - 8'h61);
    end else begin
      slot = 5'(letter_code - 8'h41);
    end
  end

  // hand the classified item to the queue
  assign in_ready            = !q_full;
  assign q_push              = in_valid && !q_full;
  assign q_item.unsupported  = !(is_upper || is_lower);
  assign q_item.segs         = (is_upper || is_lower) ? glyph_segs(slot) : '0;

endmodule

@@ design/sfgr_queue.sv @@
// two-entry queue of classified items between front and back
// depends on sfgr_pkg
`timescale 1ns / 1ps

module sfgr_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sfgr_pkg::sfgr_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output sfgr_pkg::sfgr_item_t head_item
);
  import sfgr_pkg::*;

  sfgr_item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

@@ design/sfgr_back.sv @@
// back end: rasterizes the head item one row per cycle into the output register
// when that register is free or drained; depends on sfgr_pkg
`timescale 1ns / 1ps

module sfgr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [3:0]           font_size,
  input  logic                 bold,
  input  logic                 head_valid,
  input  sfgr_pkg::sfgr_item_t head_item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [11:0]          row_bits,
  output logic [3:0]           row_number,
  output logic                 last_row,
  output logic                 unsupported
);
  import sfgr_pkg::*;

  logic [NUM_W-1:0] row;
  logic [NUM_W-1:0] n;
  logic [NUM_W-1:0] h_up;
  logic [NUM_W-1:0] h_dn;
  logic [NUM_W-1:0] mid;
  logic [NUM_W-1:0] bar;
  logic [ROW_W-1:0] full_m;
  logic [ROW_W-1:0] lo_m;
  logic [ROW_W-1:0] hi_m;
  logic [ROW_W-1:0] mask;
  logic             in_top;
  logic             in_bot;
  logic             advance;
  logic             item_done;
  logic [SEG_W-1:0] sg;

  function automatic logic [ROW_W-1:0] col_bit(input logic [NUM_W-1:0] c);
    return ROW_W'(1) << c;
  endfunction

  // clamp the glyph side and derive its geometry
  always_comb begin
    if (font_size < MIN_N) begin
      n = MIN_N;
    end else if (font_size > MAX_N) begin
      n = MAX_N;
    end else begin
      n = font_size;
    end
  end

  assign h_up   = (n + 4'd1) >> 1;
  assign h_dn   = n >> 1;
  assign mid    = (n - 4'd1) >> 1;
  assign bar    = h_dn - 4'd1;
  assign full_m = {ROW_W{1'b1}} >> (MAX_N - n);
  assign lo_m   = ~({ROW_W{1'b1}} << h_up);
  assign hi_m   = full_m & ({ROW_W{1'b1}} << h_dn);
  assign in_top = (row < h_up);
  assign in_bot = (row >= h_dn);
  assign sg     = head_item.segs;

  // union of all strokes that cross the current row
  always_comb begin
    mask = '0;
    if (|(sg & SEG_TOP)) begin
      if (row == 4'd0) mask |= full_m;
      if (bold && row == 4'd1) mask |= full_m;
    end
    if (|(sg & SEG_TL) && in_top) begin
      mask |= col_bit(4'd0);
      if (bold) mask |= col_bit(4'd1);
    end
    if (|(sg & SEG_TLD)) begin
      if (in_top) mask |= col_bit(row);
      if (bold && row >= 4'd1 && row <= h_dn) mask |= col_bit(row - 4'd1);
    end
    if (|(sg & SEG_TM) && in_top) begin
      mask |= col_bit(mid);
      if (bold) mask |= col_bit(mid + 4'd1);
    end
    if (|(sg & SEG_TRD)) begin
      if (in_top) mask |= col_bit(n - 4'd1 - row);
      if (bold && row >= 4'd1 && row <= h_dn) mask |= col_bit(n - row);
    end
    if (|(sg & SEG_TR) && in_top) begin
      mask |= col_bit(n - 4'd1);
      if (bold) mask |= col_bit(n - 4'd2);
    end
    if (|(sg & SEG_LM)) begin
      if (row == bar) mask |= lo_m;
      if (bold && row == bar + 4'd1) mask |= lo_m;
    end
    if (|(sg & SEG_RM)) begin
      if (row == bar) mask |= hi_m;
      if (bold && row == bar + 4'd1) mask |= hi_m;
    end
    if (|(sg & SEG_BL) && !in_top) begin
      mask |= col_bit(4'd0);
      if (bold) mask |= col_bit(4'd1);
    end
    if (|(sg & SEG_BLD) && in_bot) begin
      mask |= col_bit(n - 4'd1 - row);
      if (bold && row <= n - 4'd2) mask |= col_bit(n - 4'd2 - row);
    end
    if (|(sg & SEG_BM) && in_bot) begin
      mask |= col_bit(mid);
      if (bold) mask |= col_bit(mid + 4'd1);
    end
    if (|(sg & SEG_BRD) && in_bot) begin
      mask |= col_bit(row);
      if (bold && row <= n - 4'd2) mask |= col_bit(row + 4'd1);
    end
    if (|(sg & SEG_BR) && row >= bar) begin
      mask |= col_bit(n - 4'd1);
      if (bold) mask |= col_bit(n - 4'd2);
    end
    if (|(sg & SEG_BOT)) begin
      if (row == n - 4'd1) mask |= full_m;
      if (bold && row == n - 4'd2) mask |= full_m;
    end
  end

  // one row moves into the output register whenever it is free or drained
  assign advance   = head_valid && (!out_valid || out_ready);
  assign item_done = head_item.unsupported || (row == n - 4'd1);
  assign pop       = advance && item_done;

  // row counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        row       <= item_done ? 4'd0 : row + 4'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      row_bits    <= head_item.unsupported ? '0 : mask;
      row_number  <= head_item.unsupported ? '0 : row;
      last_row    <= item_done;
      unsupported <= head_item.unsupported;
    end
  end

`ifndef ASSERT_OFF
  a_unsup_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && unsupported |-> last_row && row_bits == '0 && row_number == '0)
    else $error("unsupported item with wrong shape");

  a_row_in_glyph: assert property (@(posedge clk) disable iff (rst)
    out_valid && !unsupported |-> row_number < n)
    else $error("row number outside glyph");

  a_counter_ahead: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_row |-> row == row_number + 4'd1)
    else $error("row counter out of step with output row");

  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");
`endif

endmodule

@@ verif/tb_segment_font_glyph_raster_unit.sv @@
// testbench of the segment font glyph raster unit: a glyph row predictor in a
// scoreboard class, letter and config drivers, a stalling row receiver
// depends on sfgr_pkg and segment_font_glyph_raster_unit
`timescale 1ns / 1ps

module tb_segment_font_glyph_raster_unit;
  import sfgr_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int LONG_HOLD    = 200;
  localparam int NUM_SETTINGS = 8;
  localparam int PHASE_ITEMS  = 26;

  // one glyph row as it leaves the unit
  typedef struct packed {
    logic [ROW_W-1:0] bits;
    logic [NUM_W-1:0] num;
    logic             last_flag;
    logic             unsup;
  } glyph_row_t;

  // receiver stall patterns
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  // predicts the rows of each accepted letter and checks the rows that come out
  class glyph_row_scoreboard;
    glyph_row_t       expected_rows[$];
    logic [3:0]       font_size_reg = 4'd8;
    logic             bold_reg = 1'b0;
    logic [ROW_W-1:0] raster[MAX_SIZE];
    int               failures = 0;

    function void write_reg(logic [0:0] index, logic [3:0] data);
      if (index == REG_FONT_SIZE) begin
        font_size_reg = data;
      end else if (index == REG_BOLD) begin
        bold_reg = data[0];
      end
    endfunction

    // stroke segments of each letter, slot 0 is A
    function logic [SEG_W-1:0] letter_strokes(int slot);
      case (slot)
        0:  return SEG_TOP | SEG_TL | SEG_TR | SEG_LM | SEG_RM | SEG_BL | SEG_BR;
        1:  return SEG_TOP | SEG_TM | SEG_TR | SEG_RM | SEG_BM | SEG_BR | SEG_BOT;
        2:  return SEG_TOP | SEG_TL | SEG_BL | SEG_BOT;
        3:  return SEG_TOP | SEG_TM | SEG_TR | SEG_BM | SEG_BR | SEG_BOT;
        4:  return SEG_TOP | SEG_TL | SEG_LM | SEG_BL | SEG_BOT;
        5:  return SEG_TOP | SEG_TL | SEG_LM | SEG_BL;
        6:  return SEG_TOP | SEG_TL | SEG_RM | SEG_BL | SEG_BR | SEG_BOT;
        7:  return SEG_TL | SEG_TR | SEG_RM | SEG_LM | SEG_BL | SEG_BR;
        8:  return SEG_TOP | SEG_TM | SEG_BM | SEG_BOT;
        9:  return SEG_TR | SEG_BL | SEG_BR | SEG_BOT;
        10: return SEG_TL | SEG_TRD | SEG_LM | SEG_BL | SEG_BRD;
        11: return SEG_TL | SEG_BL | SEG_BOT;
        12: return SEG_TL | SEG_TLD | SEG_TRD | SEG_TR | SEG_BL | SEG_BR;
        13: return SEG_TL | SEG_TLD | SEG_TR | SEG_BL | SEG_BRD | SEG_BR;
        14: return SEG_TOP | SEG_TL | SEG_TR | SEG_BL | SEG_BR | SEG_BOT;
        15: return SEG_TOP | SEG_TL | SEG_TR | SEG_LM | SEG_RM | SEG_BL;
        16: return SEG_TOP | SEG_TL | SEG_TR | SEG_BL | SEG_BRD | SEG_BR | SEG_BOT;
        17: return SEG_TOP | SEG_TL | SEG_TR | SEG_LM | SEG_RM | SEG_BL | SEG_BRD;
        18: return SEG_TOP | SEG_TL | SEG_LM | SEG_RM | SEG_BR | SEG_BOT;
        19: return SEG_TOP | SEG_TM | SEG_BM;
        20: return SEG_TL | SEG_TR | SEG_BL | SEG_BR | SEG_BOT;
        21: return SEG_TL | SEG_TRD | SEG_BL | SEG_BLD;
        22: return SEG_TL | SEG_TR | SEG_BL | SEG_BLD | SEG_BRD | SEG_BR;
        23: return SEG_TLD | SEG_TRD | SEG_BLD | SEG_BRD;
        24: return SEG_TLD | SEG_TRD | SEG_BM;
        default: return SEG_TOP | SEG_TRD | SEG_BLD | SEG_BOT;
      endcase
    endfunction

    // set one pixel by flat index, indexes outside the glyph are dropped
    function void mark(int n, int idx);
      if (idx >= 0 && idx < n * n) raster[idx / n][idx % n] = 1'b1;
    endfunction

    function void add_letter(logic [7:0] code);
      int n, slot, r, c, half_up, half_dn, mid_col, bar_row, last_idx;
      logic [SEG_W-1:0] segs;
      logic b;
      glyph_row_t row;
      n = int'(font_size_reg);
      if (n < int'(MIN_N)) n = int'(MIN_N);
      if (n > MAX_SIZE) n = MAX_SIZE;
      if (code >= "a" && code <= "z") begin
        slot = int'(code) - int'("a");
      end else if (code >= "A" && code <= "Z") begin
        slot = int'(code) - int'("A");
      end else begin
        slot = -1;
      end
      // not a letter: one flagged empty row
      if (slot < 0) begin
        row = '{bits: '0, num: '0, last_flag: 1'b1, unsup: 1'b1};
        expected_rows.push_back(row);
        return;
      end
      segs     = letter_strokes(slot);
      b        = bold_reg;
      half_up  = (n + 1) / 2;
      half_dn  = n / 2;
      mid_col  = (n - 1) / 2;
      bar_row  = half_dn - 1;
      last_idx = n * n - 1;
      foreach (raster[k]) raster[k] = '0;
      // edges, half edges, bars and diagonals
      if ((segs & SEG_TOP) != 0)
        for (c = 0; c < n; c++) begin mark(n, c); if (b) mark(n, n + c); end
      if ((segs & SEG_TL) != 0)
        for (r = 0; r < half_up; r++) begin mark(n, r * n); if (b) mark(n, r * n + 1); end
      if ((segs & SEG_TLD) != 0) begin
        for (r = 0; r < half_up; r++) mark(n, r * n + r);
        if (b) for (r = 1; r <= half_dn; r++) mark(n, r * n + r - 1);
      end
      if ((segs & SEG_TM) != 0)
        for (r = 0; r < half_up; r++) begin
          mark(n, mid_col + n * r);
          if (b) mark(n, mid_col + n * r + 1);
        end
      if ((segs & SEG_TRD) != 0) begin
        for (r = 1; r <= half_up; r++) mark(n, (n - 1) * r);
        if (b) for (r = 1; r <= half_dn; r++) mark(n, (r + 1) * n - r);
      end
      if ((segs & SEG_TR) != 0)
        for (r = 1; r <= half_up; r++) begin mark(n, n * r - 1); if (b) mark(n, n * r - 2); end
      if ((segs & SEG_LM) != 0)
        for (c = 0; c < half_up; c++) begin
          mark(n, n * bar_row + c);
          if (b) mark(n, n * (bar_row + 1) + c);
        end
      if ((segs & SEG_RM) != 0)
        for (c = half_dn; c < n; c++) begin
          mark(n, n * bar_row + c);
          if (b) mark(n, n * (bar_row + 1) + c);
        end
      if ((segs & SEG_BL) != 0)
        for (r = half_up; r < n; r++) begin mark(n, r * n); if (b) mark(n, r * n + 1); end
      if ((segs & SEG_BLD) != 0) begin
        for (r = n; r > half_dn; r--) mark(n, r * n - r);
        if (b) for (r = n - 1; r > half_dn; r--) mark(n, r * n - r - 1);
      end
      if ((segs & SEG_BM) != 0)
        for (r = half_dn; r < n; r++) begin
          mark(n, mid_col + n * r);
          if (b) mark(n, mid_col + n * r + 1);
        end
      if ((segs & SEG_BRD) != 0) begin
        for (r = half_dn; r < n; r++) mark(n, r * n + r);
        if (b) for (r = half_dn + 1; r < n; r++) mark(n, (r - 1) * n + r);
      end
      if ((segs & SEG_BR) != 0)
        for (r = half_dn; r <= n; r++) begin mark(n, n * r - 1); if (b) mark(n, n * r - 2); end
      if ((segs & SEG_BOT) != 0)
        for (c = 0; c < n; c++) begin mark(n, last_idx - c); if (b) mark(n, last_idx - n - c); end
      // one row per result, top first
      for (r = 0; r < n; r++) begin
        row.bits      = raster[r];
        row.num       = NUM_W'(r);
        row.last_flag = (r == n - 1);
        row.unsup     = 1'b0;
        expected_rows.push_back(row);
      end
    endfunction

    function void check_row(glyph_row_t got);
      glyph_row_t want;
      if (expected_rows.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected row: bits %03h row %0d last %0b unsup %0b",
                   got.bits, got.num, got.last_flag, got.unsup);
        return;
      end
      want = expected_rows.pop_front();
      if (got.bits != want.bits || got.num != want.num ||
          got.last_flag != want.last_flag || got.unsup != want.unsup) begin
        failures++;
        if (failures <= 10)
          $display("row mismatch: expected %03h %0d %0b %0b, got %03h %0d %0b %0b",
                   want.bits, want.num, want.last_flag, want.unsup,
                   got.bits, got.num, got.last_flag, got.unsup);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [3:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  letter_code;
  logic        out_valid;
  logic        out_ready;
  logic [11:0] row_bits;
  logic [3:0]  row_number;
  logic        last_row;
  logic        unsupported;

  glyph_row_scoreboard sb;
  logic letter_taken;
  bit   hold_req;
  int   cycle_count;

  segment_font_glyph_raster_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .letter_code (letter_code),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .row_bits    (row_bits),
    .row_number  (row_number),
    .last_row    (last_row),
    .unsupported (unsupported)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // note accepted letters first, then check the row taken at the same edge
  always @(posedge clk) begin
    if (rst) begin
      letter_taken <= 1'b0;
    end else begin
      letter_taken <= in_valid && in_ready;
      if (in_valid && in_ready) sb.add_letter(letter_code);
      if (out_valid && out_ready)
        sb.check_row('{bits: row_bits, num: row_number, last_flag: last_row,
                       unsup: unsupported});
    end
  end

  // row receiver: changing stall patterns plus one long hold-off on request
  initial begin
    int       mode_left;
    int       hold_left;
    rx_mode_t mode;
    mode_left = 0;
    hold_left = 0;
    mode      = RX_FREE;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 80);
        end
        mode_left--;
        case (mode)
          RX_FREE:  out_ready <= 1'b1;
          RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
          default:  out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // offer one letter and hold it until taken
  task automatic send_letter(logic [7:0] code);
    in_valid    <= 1'b1;
    letter_code <= code;
    do @(negedge clk); while (!letter_taken);
  endtask

  function automatic logic [7:0] random_letter();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return 8'("A" + $urandom_range(0, 25));
    if (pick < 8) return 8'("a" + $urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  // letters in bursts with random gaps, back to back when steady
  task automatic run_letters(int count, bit steady);
    int left, burst, gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        send_letter(random_letter());
        burst--;
        left--;
      end
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // wait until every predicted row has come out, then let the output settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_rows.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write both registers on consecutive edges
  task automatic program_glyph(logic [3:0] size_data, logic [3:0] bold_data);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FONT_SIZE;
    cfg_data  <= size_data;
    sb.write_reg(REG_FONT_SIZE, size_data);
    @(negedge clk);
    cfg_index <= REG_BOLD;
    cfg_data  <= bold_data;
    sb.write_reg(REG_BOLD, bold_data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // main sequence
  initial begin
    logic [7:0] directed_codes[19];
    logic [3:0] size_table[NUM_SETTINGS];
    logic       bold_table[NUM_SETTINGS];
    // non-letters on both sides of each case range, both cases, diagonal-heavy letters
    directed_codes = '{8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'hC1,
                       "A", "Z", "a", "z", "M", "W", "X", "Q", "K", "N", "Y", "I"};
    // includes sizes below 8 and above the largest glyph, which clamp
    size_table = '{4'd8, 4'd12, 4'd0, 4'd15, 4'd9, 4'd10, 4'd7, 4'd11};
    bold_table = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    sb          = new;
    hold_req    = 1'b0;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    letter_code = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed letters at the widest bold glyph, then at the reset size
    program_glyph(4'd12, 4'd1);
    foreach (directed_codes[i]) send_letter(directed_codes[i]);
    wait_idle();
    program_glyph(4'd8, 4'd0);
    foreach (directed_codes[i]) if (i >= 7 && i < 12) send_letter(directed_codes[i]);
    wait_idle();

    // random phases, one register setting each; phase two runs under a long hold
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      program_glyph(size_table[p], {4'($urandom_range(0, 7)) << 1} | 4'(bold_table[p]));
      if (p == 2) hold_req = 1'b1;
      run_letters(PHASE_ITEMS, p == 2);
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/sfgr_pkg.sv
design/sfgr_front.sv
design/sfgr_queue.sv
design/sfgr_back.sv
design/segment_font_glyph_raster_unit.sv
verif/tb_segment_font_glyph_raster_unit.sv
